@@ rtl/fla_pkg.sv @@
// Shared types and constants for the free-list heap allocator.
// Holds the request/response payload structs, the controller command and status structs,
// and the request, status, fit-mode and register index codes. No dependencies.
`default_nettype none

package fla_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 17;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIT_MODE   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEAP_LIMIT = 1'd1;

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_FREE    = 2'd1,
      REQ_INFO    = 2'd2,
      REQ_RESTART = 2'd3
   } fla_kind_type;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_SIZE   = 2'd1;
   localparam logic [1:0] ST_HEAP_LIMIT = 2'd2;
   localparam logic [1:0] ST_TABLE_FULL = 2'd3;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [16:0] req_size;
      logic [15:0] release_offset;
   } fla_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] payload_offset;
      logic [16:0] free_bytes;
      logic [5:0]  list_chunks;
      logic [16:0] largest_chunk;
      logic [16:0] smallest_chunk;
   } fla_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       restart;
      logic       pick;
      logic       grow_adv;
      logic       take_sel;
      logic       take_grow;
      logic       alloc_fin;
      logic       take_size;
      logic       merge;
      logic       free_push;
      logic       info_acc;
      logic       set_status;
      logic [1:0] status_val;
      logic       emit;
      logic       emit_info;
   } fla_cmd_type;

   // Conditions reported by the datapath to the controller.
   typedef struct packed {
      logic zero_size;
      logic free_skip;
      logic scan_end;
      logic found;
      logic grow_short;
      logic grow_over;
      logic split_full;
      logic merged;
      logic full;
      logic out_free;
   } fla_stat_type;

endpackage

`default_nettype wire

@@ rtl/free_list_heap_allocator.sv @@
// Top level of the free-list heap allocator.
// Instantiates the controller fla_ctrl and the datapath fla_dp. Depends on fla_pkg.
`default_nettype none

// The block manages a heap region through an ordered table of free blocks and
// answers one response for every request transfer: allocate (first, best or
// worst fit, growing the break in steps of GROW_STEP within the heap limit and
// splitting off large remainders), free (coalescing with touching free blocks),
// info (free bytes, chunk count, largest and smallest chunk) and restart. It
// handles one request at a time. The table is walked one entry per cycle,
// and the walk of a free starts over after each merge. The response sits
// in an output register, so a new request is taken as soon as the previous
// one has been placed there, even if its response transfer is still stalled.
// The block size memory needs no clearing pass. Configuration writes are
// taken at any edge but should only be made while the block is idle.
module free_list_heap_allocator #(
   parameter int unsigned HEAP_BYTES   = 65536,
   parameter int unsigned FREE_SLOTS   = 32,
   parameter int unsigned GROW_STEP    = 4096,
   parameter int unsigned HEADER_BYTES = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire fla_pkg::fla_req_type                req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output fla_pkg::fla_rsp_type                     rsp_data,
   input  wire logic                                csr_write_en,
   input  wire logic [fla_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [fla_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   fla_pkg::fla_cmd_type  cmd;
   fla_pkg::fla_stat_type stat;

   // The controller sequences each request; of the request data it sees only the request kind.
   fla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds all heap state and the response register.
   fla_dp #(
      .HEAP_BYTES   (HEAP_BYTES),
      .FREE_SLOTS   (FREE_SLOTS),
      .GROW_STEP    (GROW_STEP),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/fla_ctrl.sv @@
// Sequencing state machine of the free-list heap allocator.
// Issues fla_pkg::fla_cmd_type commands and reacts to fla_pkg::fla_stat_type conditions.
// Depends on fla_pkg.
`default_nettype none

module fla_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_kind,
   output logic                       req_stall,
   output fla_pkg::fla_cmd_type       cmd,
   input  wire fla_pkg::fla_stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_SCAN,
      S_A_DEC,
      S_A_GROW,
      S_A_FIN,
      S_F_GET,
      S_F_SCAN,
      S_F_END,
      S_I_SCAN,
      S_DONE,
      S_DONE_INFO
   } fla_state_type;

   fla_state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_kind)
                  fla_pkg::REQ_ALLOC: begin
                     if (stat.zero_size) begin
                        cmd.set_status = 1'b1;
                        cmd.status_val = fla_pkg::ST_BAD_SIZE;
                        state_in       = S_DONE;
                     end else begin
                        state_in = S_A_SCAN;
                     end
                  end
                  fla_pkg::REQ_FREE: begin
                     state_in = stat.free_skip ? S_DONE : S_F_GET;
                  end
                  fla_pkg::REQ_INFO: begin
                     state_in = S_I_SCAN;
                  end
                  default: begin
                     cmd.restart = 1'b1;
                     state_in    = S_DONE;
                  end
               endcase
            end
         end
         S_A_SCAN: begin
            if (stat.scan_end) begin
               state_in = S_A_DEC;
            end else begin
               cmd.pick = 1'b1;
            end
         end
         S_A_DEC: begin
            if (stat.found) begin
               cmd.take_sel = 1'b1;
               state_in     = S_A_FIN;
            end else begin
               state_in = S_A_GROW;
            end
         end
         S_A_GROW: begin
            if (stat.grow_short) begin
               cmd.grow_adv = 1'b1;
            end else if (stat.grow_over) begin
               cmd.set_status = 1'b1;
               cmd.status_val = fla_pkg::ST_HEAP_LIMIT;
               state_in       = S_DONE;
            end else if (stat.split_full) begin
               cmd.set_status = 1'b1;
               cmd.status_val = fla_pkg::ST_TABLE_FULL;
               state_in       = S_DONE;
            end else begin
               cmd.take_grow = 1'b1;
               state_in      = S_A_FIN;
            end
         end
         S_A_FIN: begin
            cmd.alloc_fin = 1'b1;
            state_in      = S_DONE;
         end
         S_F_GET: begin
            cmd.take_size = 1'b1;
            state_in      = S_F_SCAN;
         end
         S_F_SCAN: begin
            if (stat.scan_end) begin
               state_in = S_F_END;
            end else begin
               cmd.merge = 1'b1;
            end
         end
         S_F_END: begin
            if (!stat.merged && stat.full) begin
               cmd.set_status = 1'b1;
               cmd.status_val = fla_pkg::ST_TABLE_FULL;
            end else begin
               cmd.free_push = 1'b1;
            end
            state_in = S_DONE;
         end
         S_I_SCAN: begin
            if (stat.scan_end) begin
               state_in = S_DONE_INFO;
            end else begin
               cmd.info_acc = 1'b1;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DONE_INFO: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_info = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fla_dp.sv @@
// Datapath of the free-list heap allocator: free table, break, block size memory,
// scan counters, accumulators, configuration registers and the response register.
// Depends on fla_pkg.
`default_nettype none

module fla_dp #(
   parameter int unsigned HEAP_BYTES   = 65536,
   parameter int unsigned FREE_SLOTS   = 32,
   parameter int unsigned GROW_STEP    = 4096,
   parameter int unsigned HEADER_BYTES = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire fla_pkg::fla_req_type                   req_data,
   input  wire logic                                   csr_write_en,
   input  wire logic [fla_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [fla_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  wire fla_pkg::fla_cmd_type                   cmd,
   output fla_pkg::fla_stat_type                       stat,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output fla_pkg::fla_rsp_type                        rsp_data
);

   localparam int unsigned XW          = $clog2(FREE_SLOTS);
   localparam int unsigned CW          = $clog2(FREE_SLOTS + 1);
   localparam int unsigned STORE_DEPTH = HEAP_BYTES / 8;
   localparam int unsigned SW          = $clog2(STORE_DEPTH);

   // Configuration.
   logic [1:0]  fit_mode_ff;
   logic [16:0] limit_ff;

   // Free table and heap state.
   logic [15:0]   ent_off_ff  [FREE_SLOTS];
   logic [16:0]   ent_size_ff [FREE_SLOTS];
   logic [CW-1:0] count_ff;
   logic [16:0]   hb_ff;

   // Block size memory.
   logic [16:0] store_mem [STORE_DEPTH];
   logic [16:0] rd_ff;

   // Working registers of one request.
   logic [CW-1:0] scan_ff;
   logic [17:0]   total_ff;
   logic [15:0]   bstart_ff;
   logic [16:0]   bsize_ff;
   logic          found_ff;
   logic [XW-1:0] sel_ff;
   logic [15:0]   sel_off_ff;
   logic [16:0]   sel_size_ff;
   logic          merged_ff;
   logic [17:0]   grow_ff;
   logic [16:0]   start_ff;
   logic [17:0]   csize_ff;
   logic [16:0]   sum_ff;
   logic [16:0]   big_ff;
   logic [16:0]   small_ff;
   logic [1:0]    res_status_ff;
   logic [15:0]   res_payload_ff;

   fla_pkg::fla_rsp_type rsp_ff;
   logic                 rsp_valid_ff;

   // Current table entry under the scan index.
   logic [XW-1:0] cur_idx;
   logic [15:0]   cur_off;
   logic [16:0]   cur_size;
   logic          scan_end;
   logic          full;

   assign cur_idx  = scan_ff[XW-1:0];
   assign cur_off  = ent_off_ff[cur_idx];
   assign cur_size = ent_size_ff[cur_idx];
   assign scan_end = (scan_ff >= count_ff);
   assign full     = (32'(count_ff) >= FREE_SLOTS);

   // Effective growth limit.
   logic [16:0] lim;
   assign lim = (32'(limit_ff) < HEAP_BYTES) ? limit_ff : 17'(HEAP_BYTES);

   // Request decode at load time.
   logic [18:0] total_raw;
   logic [17:0] req_total;
   logic [15:0] rel_bstart;
   logic        free_skip;
   assign total_raw  = 19'(req_data.req_size) + 19'(HEADER_BYTES) + 19'd7;
   assign req_total  = {total_raw[17:3], 3'b000};
   assign rel_bstart = req_data.release_offset - 16'(HEADER_BYTES);
   assign free_skip  = (32'(req_data.release_offset) < HEADER_BYTES)
                       || (rel_bstart[2:0] != 3'd0)
                       || ({1'b0, rel_bstart} >= hb_ff)
                       || (32'(rel_bstart[15:3]) >= STORE_DEPTH);

   // Fit selection.
   logic fits;
   logic take_it;
   logic is_best;
   assign fits    = ({1'b0, cur_size} >= total_ff);
   assign is_best = (fit_mode_ff == fla_pkg::FIT_BEST);
   assign take_it = fits && (!found_ff
                    || ((fit_mode_ff != fla_pkg::FIT_FIRST)
                        && (is_best ? (cur_size < sel_size_ff) : (cur_size > sel_size_ff))));

   // Coalescing adjacency.
   logic merge_lo;
   logic merge_hi;
   logic merge_any;
   assign merge_lo  = ((18'(cur_off) + 18'(cur_size)) == 18'(bstart_ff));
   assign merge_hi  = ((18'(bstart_ff) + 18'(bsize_ff)) == 18'(cur_off));
   assign merge_any = cmd.merge && !scan_end && (merge_lo || merge_hi);

   // Growth.
   logic [18:0] grow_end;
   logic [17:0] grow_rem;
   assign grow_end = 19'(hb_ff) + 19'(grow_ff);
   assign grow_rem = grow_ff - total_ff;

   // Allocation finish: split and size store.
   logic [17:0] rem;
   logic        split;
   logic [17:0] split_off;
   logic [16:0] store_wdata;
   logic        store_in_range;
   assign rem            = csize_ff - total_ff;
   assign split          = (csize_ff > total_ff) && (32'(rem) > HEADER_BYTES);
   assign split_off      = 18'(start_ff) + total_ff;
   assign store_wdata    = split ? total_ff[16:0] : csize_ff[16:0];
   assign store_in_range = (32'(start_ff[16:3]) < STORE_DEPTH);

   // Info accumulation.
   logic [16:0] avail;
   logic [17:0] sum_raw;
   assign avail   = (32'(cur_size) > HEADER_BYTES) ? (cur_size - 17'(HEADER_BYTES)) : 17'd0;
   assign sum_raw = 18'(sum_ff) + 18'(avail);

   // Table shift control.
   logic          do_remove;
   logic [XW-1:0] rm_idx;
   logic          do_push;
   logic [15:0]   push_off;
   logic [16:0]   push_size;
   assign do_remove = cmd.take_sel || merge_any;
   assign rm_idx    = cmd.take_sel ? sel_ff : cur_idx;
   assign do_push   = ((cmd.alloc_fin && split) || cmd.free_push) && !full;
   assign push_off  = cmd.free_push ? bstart_ff : split_off[15:0];
   assign push_size = cmd.free_push ? bsize_ff : rem[16:0];

   always_comb begin
      stat            = '0;
      stat.zero_size  = (req_data.req_size == 17'd0);
      stat.free_skip  = free_skip;
      stat.scan_end   = scan_end;
      stat.found      = found_ff;
      stat.grow_short = (grow_ff < total_ff);
      stat.grow_over  = (grow_end > 19'(lim));
      stat.split_full = (32'(grow_rem) > HEADER_BYTES) && full;
      stat.merged     = merged_ff;
      stat.full       = full;
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Free table contents.
   always_ff @(posedge clock) begin
      for (int k = 0; k < FREE_SLOTS; k++) begin
         if (do_push) begin
            if (k == 0) begin
               ent_off_ff[k]  <= push_off;
               ent_size_ff[k] <= push_size;
            end else begin
               ent_off_ff[k]  <= ent_off_ff[k-1];
               ent_size_ff[k] <= ent_size_ff[k-1];
            end
         end else if (do_remove && (k < FREE_SLOTS - 1) && (XW'(k) >= rm_idx)) begin
            ent_off_ff[k]  <= ent_off_ff[k+1];
            ent_size_ff[k] <= ent_size_ff[k+1];
         end
      end
   end

   // Block size memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.alloc_fin && store_in_range) begin
         store_mem[SW'(start_ff[16:3])] <= store_wdata;
      end
      rd_ff <= store_mem[SW'(rel_bstart[15:3])];
   end

   // Control state: configuration, table count, break, response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff  <= 2'd0;
         limit_ff     <= 17'd0;
         count_ff     <= '0;
         hb_ff        <= 17'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               fla_pkg::CSR_FIT_MODE:   fit_mode_ff <= csr_wdata[1:0];
               fla_pkg::CSR_HEAP_LIMIT: limit_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.restart) begin
            count_ff <= '0;
            hb_ff    <= 17'd0;
         end else begin
            if (do_push) begin
               count_ff <= count_ff + CW'(1);
            end else if (do_remove) begin
               count_ff <= count_ff - CW'(1);
            end
            if (cmd.take_grow) begin
               hb_ff <= grow_end[16:0];
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the request in flight.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         scan_ff        <= '0;
         total_ff       <= req_total;
         bstart_ff      <= rel_bstart;
         found_ff       <= 1'b0;
         merged_ff      <= 1'b0;
         grow_ff        <= 18'(GROW_STEP);
         sum_ff         <= 17'd0;
         big_ff         <= 17'd0;
         small_ff       <= 17'd0;
         // A request rejected at the transfer gets its status right away.
         res_status_ff  <= cmd.set_status ? cmd.status_val : fla_pkg::ST_OK;
         res_payload_ff <= 16'd0;
      end else begin
         if (cmd.pick) begin
            if (take_it) begin
               found_ff    <= 1'b1;
               sel_ff      <= cur_idx;
               sel_off_ff  <= cur_off;
               sel_size_ff <= cur_size;
            end
            scan_ff <= scan_ff + CW'(1);
         end
         if (cmd.grow_adv) begin
            grow_ff <= grow_ff + 18'(GROW_STEP);
         end
         if (cmd.take_sel) begin
            start_ff <= {1'b0, sel_off_ff};
            csize_ff <= {1'b0, sel_size_ff};
         end
         if (cmd.take_grow) begin
            start_ff <= hb_ff;
            csize_ff <= grow_ff;
         end
         if (cmd.alloc_fin) begin
            res_status_ff  <= fla_pkg::ST_OK;
            res_payload_ff <= 16'(start_ff + 17'(HEADER_BYTES));
         end
         if (cmd.take_size) begin
            bsize_ff <= rd_ff;
         end
         if (cmd.merge) begin
            if (merge_any) begin
               if (merge_lo) begin
                  bstart_ff <= cur_off;
               end
               bsize_ff  <= bsize_ff + cur_size;
               merged_ff <= 1'b1;
               scan_ff   <= '0;
            end else begin
               scan_ff <= scan_ff + CW'(1);
            end
         end
         if (cmd.info_acc) begin
            sum_ff <= sum_raw[17] ? 17'h1FFFF : sum_raw[16:0];
            if (scan_ff == '0) begin
               big_ff   <= avail;
               small_ff <= avail;
            end else begin
               if (avail > big_ff) begin
                  big_ff <= avail;
               end
               if (avail < small_ff) begin
                  small_ff <= avail;
               end
            end
            scan_ff <= scan_ff + CW'(1);
         end
         if (cmd.set_status) begin
            res_status_ff <= cmd.status_val;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.status         <= res_status_ff;
         rsp_ff.payload_offset <= res_payload_ff;
         if (cmd.emit_info) begin
            rsp_ff.free_bytes     <= sum_ff;
            rsp_ff.list_chunks    <= 6'(count_ff);
            rsp_ff.largest_chunk  <= big_ff;
            rsp_ff.smallest_chunk <= small_ff;
         end else begin
            rsp_ff.free_bytes     <= 17'd0;
            rsp_ff.list_chunks    <= 6'd0;
            rsp_ff.largest_chunk  <= 17'd0;
            rsp_ff.smallest_chunk <= 17'd0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= FREE_SLOTS)
      else $error("free table count above its capacity");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while a transfer is pending");

   a_restart_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.restart |=> (count_ff == '0) && (hb_ff == 17'd0))
      else $error("restart left table or break nonzero");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.free_push |-> (merged_ff || !full))
      else $error("free pushed into a full table");
`endif

endmodule

`default_nettype wire
